// File: hdl/pthc_pkg.sv
package pthc_pkg;

    localparam int unsigned NUM_FRONT_STAGES = 11;
    localparam int unsigned NUM_DIV_STAGES   = 64;
    localparam int unsigned NUM_POST_STAGES  = 7;
    localparam int unsigned NUM_STAGES       = NUM_FRONT_STAGES + NUM_DIV_STAGES
                                               + NUM_POST_STAGES;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_CAL      = 3'd0,
        CFG_PRESS_CAL_LO  = 3'd1,
        CFG_PRESS_CAL_HI  = 3'd2,
        CFG_PRESS_HUM_CAL = 3'd3,
        CFG_HUM_CAL       = 3'd4
    } t_cfg_idx;

    localparam logic [19:0] RAW_T_ALL_ONES = 20'hFFFFF;
    localparam logic [31:0] T_FINE_P_OFS   = 32'd128000;
    localparam logic [20:0] P_RAW_FULL     = 21'd1048576;
    localparam logic [31:0] P_SCALE        = 32'd3125;
    localparam logic [31:0] T_FINE_H_OFS   = 32'd76800;
    localparam logic [31:0] H_ROUND_X      = 32'd16384;
    localparam logic [31:0] H_OFS_B        = 32'd32768;
    localparam logic [31:0] H_OFS_Y        = 32'd2097152;
    localparam logic [31:0] H_ROUND_Y      = 32'd8192;
    localparam logic [31:0] H_MAX          = 32'd419430400;
    localparam logic [63:0] P_DIV_BIAS     = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic               rv;
        logic               neg;
        logic               dz;
        logic signed [15:0] tc;
        logic [16:0]        hum;
    } t_side;

    typedef struct packed {
        logic [30:0] rem;
        logic [63:0] qn;
    } t_div;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div div_step(input logic [30:0] rem, input logic [63:0] qn,
                                      input logic [30:0] dmag);
        logic [31:0] sh;
        logic [32:0] diff;
        t_div        res;
        sh   = {rem, qn[63]};
        diff = {1'b0, sh} - {2'b00, dmag};
        if (!diff[32]) begin
            res.rem = diff[30:0];
            res.qn  = {qn[62:0], 1'b1};
        end else begin
            res.rem = sh[30:0];
            res.qn  = {qn[62:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// File: hdl/pth_sensor_compensation.sv
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+------------------------------------
// in       | to block  | i_in_valid / o_in_ready      | raw pressure, temperature, humidity
// out      | from block| o_out_valid / i_out_ready    | valid flag, temp, pressure, flag, hum
// cfg      | to block  | i_cfg_valid / o_cfg_ready    | register index, write data
//
// one transaction per cycle in, one per cycle out, unless the output is held or a cfg write waits
// most of the pipeline depth is the 64-stage bit-per-stage pressure divider
// synchronous active-low reset clears stage valids and calibration registers
// a held output freezes the whole pipeline; o_in_ready is also low while a cfg write waits
// cfg writes are taken only while the pipeline is empty
module pth_sensor_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [19:0]                         i_raw_pressure,
    input  logic [19:0]                         i_raw_temperature,
    input  logic [15:0]                         i_raw_humidity,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_reading_valid,
    output logic signed [15:0]                  o_temperature_centi,
    output logic [31:0]                         o_pressure_q24_8,
    output logic                                o_pressure_divisor_zero,
    output logic [16:0]                         o_humidity_q22_10,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pthc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pthc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pthc_pkg::*;

    logic [47:0] r_temp_cal;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [47:0] r_ph_cal;
    logic [31:0] r_hum_cal;

    // pipeline control: everything moves together unless the output is held
    logic                  w_adv;
    logic [NUM_STAGES-1:0] r_vld;

    assign w_adv       = !r_vld[NUM_STAGES-1] || i_out_ready;
    assign o_in_ready  = w_adv && !i_cfg_valid;
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_cfg_ready = (r_vld == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_in_valid && o_in_ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal <= '0;
            r_press_lo <= '0;
            r_press_hi <= '0;
            r_ph_cal   <= '0;
            r_hum_cal  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEMP_CAL:      r_temp_cal <= i_cfg_data[47:0];
                CFG_PRESS_CAL_LO:  r_press_lo <= i_cfg_data;
                CFG_PRESS_CAL_HI:  r_press_hi <= i_cfg_data;
                CFG_PRESS_HUM_CAL: r_ph_cal   <= i_cfg_data[47:0];
                CFG_HUM_CAL:       r_hum_cal  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // calibration fields
    logic [15:0]        w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9, w_h2;
    logic [7:0]         w_h1, w_h3;
    logic signed [11:0] w_h4, w_h5;
    logic signed [7:0]  w_h6;

    assign w_t1 = r_temp_cal[15:0];
    assign w_t2 = r_temp_cal[31:16];
    assign w_t3 = r_temp_cal[47:32];
    assign w_p1 = r_press_lo[15:0];
    assign w_p2 = r_press_lo[31:16];
    assign w_p3 = r_press_lo[47:32];
    assign w_p4 = r_press_lo[63:48];
    assign w_p5 = r_press_hi[15:0];
    assign w_p6 = r_press_hi[31:16];
    assign w_p7 = r_press_hi[47:32];
    assign w_p8 = r_press_hi[63:48];
    assign w_p9 = r_ph_cal[15:0];
    assign w_h1 = r_ph_cal[23:16];
    assign w_h2 = r_ph_cal[39:24];
    assign w_h3 = r_ph_cal[47:40];
    assign w_h4 = r_hum_cal[11:0];
    assign w_h5 = r_hum_cal[23:12];
    assign w_h6 = r_hum_cal[31:24];

    // stage 1: fine temperature products
    logic signed [17:0] w_x1;
    logic signed [16:0] w_d;
    logic               r1_rv;
    logic [19:0]        r1_adc_p;
    logic [15:0]        r1_adc_h;
    logic signed [33:0] r1_m1, r1_dd;

    assign w_x1 = $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_d  = $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, w_t1});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_rv    <= (i_raw_temperature != '0) && (i_raw_temperature != RAW_T_ALL_ONES);
            r1_adc_p <= i_raw_pressure;
            r1_adc_h <= i_raw_humidity;
            r1_m1    <= w_x1 * w_t2;
            r1_dd    <= w_d * w_d;
        end
    end

    // stage 2
    logic               r2_rv;
    logic [19:0]        r2_adc_p;
    logic [15:0]        r2_adc_h;
    logic signed [22:0] r2_v1;
    logic signed [37:0] r2_e;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_rv    <= r1_rv;
            r2_adc_p <= r1_adc_p;
            r2_adc_h <= r1_adc_h;
            r2_v1    <= r1_m1[33:11];
            r2_e     <= $signed(r1_dd[33:12]) * w_t3;
        end
    end

    // stage 3: fine temperature
    logic               r3_rv;
    logic [19:0]        r3_adc_p;
    logic [15:0]        r3_adc_h;
    logic signed [31:0] r3_tf;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_rv    <= r2_rv;
            r3_adc_p <= r2_adc_p;
            r3_adc_h <= r2_adc_h;
            r3_tf    <= {{9{r2_v1[22]}}, r2_v1} + {{8{r2_e[37]}}, r2_e[37:14]};
        end
    end

    // stage 4: temperature output, first pressure and humidity products
    logic [35:0]        w_t5;
    logic signed [27:0] w_tc;
    logic signed [31:0] w_a;
    logic [31:0]        w_hv;
    logic               r4_rv;
    logic [19:0]        r4_adc_p;
    logic [15:0]        r4_adc_h;
    logic signed [15:0] r4_tc;
    logic signed [63:0] r4_aa;
    logic signed [47:0] r4_ap5, r4_ap2;
    logic [31:0]        r4_h5hv, r4_t6, r4_t3;

    assign w_t5 = {{4{r3_tf[31]}}, r3_tf} * 36'd5 + 36'd128;
    assign w_tc = w_t5[35:8];
    assign w_a  = r3_tf - $signed(T_FINE_P_OFS);
    assign w_hv = r3_tf - T_FINE_H_OFS;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_rv    <= r3_rv;
            r4_adc_p <= r3_adc_p;
            r4_adc_h <= r3_adc_h;
            if (w_tc > 28'sd32767) begin
                r4_tc <= 16'sh7FFF;
            end else if (w_tc < -28'sd32768) begin
                r4_tc <= 16'sh8000;
            end else begin
                r4_tc <= w_tc[15:0];
            end
            r4_aa   <= w_a * w_a;
            r4_ap5  <= w_a * w_p5;
            r4_ap2  <= w_a * w_p2;
            r4_h5hv <= w_hv * {{20{w_h5[11]}}, w_h5};
            r4_t6   <= w_hv * {{24{w_h6[7]}}, w_h6};
            r4_t3   <= w_hv * {24'd0, w_h3};
        end
    end

    // stage 5: partial products of the squared terms, humidity x and y terms
    logic [31:0]        w_hx0, w_ta, w_tb;
    logic               r5_rv;
    logic [19:0]        r5_adc_p;
    logic signed [15:0] r5_tc;
    logic signed [48:0] r5_b6lo, r5_c3lo;
    logic signed [47:0] r5_b6hi, r5_c3hi;
    logic signed [47:0] r5_ap5, r5_ap2;
    logic [31:0]        r5_hx, r5_hy;

    assign w_hx0 = {2'b00, r4_adc_h, 14'd0} - {w_h4, 20'd0} - r4_h5hv + H_ROUND_X;
    assign w_ta  = {{10{r4_t6[31]}}, r4_t6[31:10]};
    assign w_tb  = {{11{r4_t3[31]}}, r4_t3[31:11]} + H_OFS_B;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_rv    <= r4_rv;
            r5_adc_p <= r4_adc_p;
            r5_tc    <= r4_tc;
            r5_b6lo  <= $signed({1'b0, r4_aa[31:0]}) * w_p6;
            r5_b6hi  <= $signed(r4_aa[63:32]) * w_p6;
            r5_c3lo  <= $signed({1'b0, r4_aa[31:0]}) * w_p3;
            r5_c3hi  <= $signed(r4_aa[63:32]) * w_p3;
            r5_ap5   <= r4_ap5;
            r5_ap2   <= r4_ap2;
            r5_hx    <= {{15{w_hx0[31]}}, w_hx0[31:15]};
            r5_hy    <= w_ta * w_tb;
        end
    end

    // stage 6
    logic [31:0]        w_hy2;
    logic               r6_rv;
    logic [19:0]        r6_adc_p;
    logic signed [15:0] r6_tc;
    logic [63:0]        r6_b1, r6_c1;
    logic signed [47:0] r6_ap5, r6_ap2;
    logic [31:0]        r6_hx, r6_hy;

    assign w_hy2 = {{10{r5_hy[31]}}, r5_hy[31:10]} + H_OFS_Y;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_rv    <= r5_rv;
            r6_adc_p <= r5_adc_p;
            r6_tc    <= r5_tc;
            r6_b1    <= {{15{r5_b6lo[48]}}, r5_b6lo} + {r5_b6hi[31:0], 32'd0};
            r6_c1    <= {{15{r5_c3lo[48]}}, r5_c3lo} + {r5_c3hi[31:0], 32'd0};
            r6_ap5   <= r5_ap5;
            r6_ap2   <= r5_ap2;
            r6_hx    <= r5_hx;
            r6_hy    <= w_hy2 * {{16{w_h2[15]}}, w_h2};
        end
    end

    // stage 7
    logic [31:0]        w_hyf, w_hyr;
    logic               r7_rv;
    logic [19:0]        r7_adc_p;
    logic signed [15:0] r7_tc;
    logic [63:0]        r7_b, r7_a2;
    logic [31:0]        r7_hh;

    assign w_hyr = r6_hy + H_ROUND_Y;
    assign w_hyf = {{14{w_hyr[31]}}, w_hyr[31:14]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_rv    <= r6_rv;
            r7_adc_p <= r6_adc_p;
            r7_tc    <= r6_tc;
            r7_b     <= r6_b1 + {r6_ap5[46:0], 17'd0}
                        + {{13{w_p4[15]}}, w_p4, 35'd0};
            r7_a2    <= {{8{r6_c1[63]}}, r6_c1[63:8]} + {{4{r6_ap2[47]}}, r6_ap2, 12'd0};
            r7_hh    <= r6_hx * w_hyf;
        end
    end

    // stage 8: divisor product halves, numerator before scaling
    logic [63:0]        w_u;
    logic [20:0]        w_p0;
    logic [31:0]        w_hs;
    logic               r8_rv;
    logic signed [15:0] r8_tc;
    logic [47:0]        r8_u1lo;
    logic [31:0]        r8_u1hi;
    logic [63:0]        r8_n1;
    logic [31:0]        r8_sq, r8_hh;

    assign w_u  = P_DIV_BIAS + r7_a2;
    assign w_p0 = P_RAW_FULL - {1'b0, r7_adc_p};
    assign w_hs = {{15{r7_hh[31]}}, r7_hh[31:15]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_rv   <= r7_rv;
            r8_tc   <= r7_tc;
            r8_u1lo <= w_u[31:0] * w_p1;
            r8_u1hi <= w_u[63:32] * {16'd0, w_p1};
            r8_n1   <= {12'd0, w_p0, 31'd0} - r7_b;
            r8_sq   <= w_hs * w_hs;
            r8_hh   <= r7_hh;
        end
    end

    // stage 9
    logic               r9_rv;
    logic signed [15:0] r9_tc;
    logic [63:0]        r9_prod;
    logic [43:0]        r9_nlo;
    logic [31:0]        r9_nhi;
    logic [31:0]        r9_hm, r9_hh;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_rv   <= r8_rv;
            r9_tc   <= r8_tc;
            r9_prod <= {16'd0, r8_u1lo} + {r8_u1hi, 32'd0};
            r9_nlo  <= r8_n1[31:0] * P_SCALE[11:0];
            r9_nhi  <= r8_n1[63:32] * P_SCALE;
            r9_hm   <= {{7{r8_sq[31]}}, r8_sq[31:7]} * {24'd0, w_h1};
            r9_hh   <= r8_hh;
        end
    end

    // stage 10: divisor, numerator, humidity clamp
    logic [31:0]        w_hh2;
    logic [28:0]        w_hcl;
    logic               r10_rv;
    logic signed [15:0] r10_tc;
    logic [30:0]        r10_den;
    logic [63:0]        r10_num;
    logic [16:0]        r10_hum;

    assign w_hh2 = r9_hh - {{4{r9_hm[31]}}, r9_hm[31:4]};

    always_comb begin
        if (w_hh2[31]) begin
            w_hcl = '0;
        end else if (w_hh2 > H_MAX) begin
            w_hcl = H_MAX[28:0];
        end else begin
            w_hcl = w_hh2[28:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_rv  <= r9_rv;
            r10_tc  <= r9_tc;
            r10_den <= r9_prod[63:33];
            r10_num <= {20'd0, r9_nlo} + {r9_nhi, 32'd0};
            r10_hum <= w_hcl[28:12];
        end
    end

    // stage 11: signs and magnitudes for the divider
    t_side       r11_side;
    logic [63:0] r11_nmag;
    logic [30:0] r11_dmag;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r11_side.rv  <= r10_rv;
            r11_side.neg <= r10_num[63] ^ r10_den[30];
            r11_side.dz  <= (r10_den == '0);
            r11_side.tc  <= r10_tc;
            r11_side.hum <= r10_hum;
            r11_nmag     <= r10_num[63] ? (~r10_num + 64'd1) : r10_num;
            r11_dmag     <= r10_den[30] ? (~r10_den + 31'd1) : r10_den;
        end
    end

    // divider: one quotient bit per stage
    t_div        w_step  [NUM_DIV_STAGES];
    t_side       r_dv_side [NUM_DIV_STAGES];
    logic [30:0] r_dv_rem  [NUM_DIV_STAGES];
    logic [63:0] r_dv_qn   [NUM_DIV_STAGES];
    logic [30:0] r_dv_dmag [NUM_DIV_STAGES];

    always_comb begin
        w_step[0] = div_step(31'd0, r11_nmag, r11_dmag);
        for (int k = 1; k < NUM_DIV_STAGES; k++) begin
            w_step[k] = div_step(r_dv_rem[k-1], r_dv_qn[k-1], r_dv_dmag[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_side[0] <= r11_side;
            r_dv_dmag[0] <= r11_dmag;
            r_dv_rem[0]  <= w_step[0].rem;
            r_dv_qn[0]   <= w_step[0].qn;
            for (int k = 1; k < NUM_DIV_STAGES; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
                r_dv_dmag[k] <= r_dv_dmag[k-1];
                r_dv_rem[k]  <= w_step[k].rem;
                r_dv_qn[k]   <= w_step[k].qn;
            end
        end
    end

    // post 1: signed quotient
    t_side       r_q1_side;
    logic [63:0] r_q1_p;
    logic [63:0] w_qmag;

    assign w_qmag = r_dv_qn[NUM_DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q1_side <= r_dv_side[NUM_DIV_STAGES-1];
            r_q1_p    <= r_dv_side[NUM_DIV_STAGES-1].neg ? (~w_qmag + 64'd1) : w_qmag;
        end
    end

    // post 2: partial products of p9*x and p8*p
    logic [63:0]        w_x;
    t_side              r_q2_side;
    logic [63:0]        r_q2_p, r_q2_x;
    logic signed [48:0] r_q2_ylo, r_q2_dlo;
    logic [31:0]        r_q2_yhi, r_q2_dhi;

    assign w_x = {{13{r_q1_p[63]}}, r_q1_p[63:13]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q2_side <= r_q1_side;
            r_q2_p    <= r_q1_p;
            r_q2_x    <= w_x;
            r_q2_ylo  <= $signed({1'b0, w_x[31:0]}) * w_p9;
            r_q2_yhi  <= w_x[63:32] * {{16{w_p9[15]}}, w_p9};
            r_q2_dlo  <= $signed({1'b0, r_q1_p[31:0]}) * w_p8;
            r_q2_dhi  <= r_q1_p[63:32] * {{16{w_p8[15]}}, w_p8};
        end
    end

    // post 3
    logic [63:0] w_dfull;
    t_side       r_q3_side;
    logic [63:0] r_q3_p, r_q3_x, r_q3_y, r_q3_d;

    assign w_dfull = {{15{r_q2_dlo[48]}}, r_q2_dlo} + {r_q2_dhi, 32'd0};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q3_side <= r_q2_side;
            r_q3_p    <= r_q2_p;
            r_q3_x    <= r_q2_x;
            r_q3_y    <= {{15{r_q2_ylo[48]}}, r_q2_ylo} + {r_q2_yhi, 32'd0};
            r_q3_d    <= {{19{w_dfull[63]}}, w_dfull[63:19]};
        end
    end

    // post 4: low 64 bits of y*x from three 32x32 products
    t_side       r_q4_side;
    logic [63:0] r_q4_p, r_q4_d, r_q4_z0;
    logic [31:0] r_q4_z1, r_q4_z2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q4_side <= r_q3_side;
            r_q4_p    <= r_q3_p;
            r_q4_d    <= r_q3_d;
            r_q4_z0   <= r_q3_y[31:0] * r_q3_x[31:0];
            r_q4_z1   <= r_q3_y[31:0] * r_q3_x[63:32];
            r_q4_z2   <= r_q3_y[63:32] * r_q3_x[31:0];
        end
    end

    // post 5
    logic [63:0] w_z;
    t_side       r_q5_side;
    logic [63:0] r_q5_p, r_q5_d, r_q5_c;

    assign w_z = r_q4_z0 + {r_q4_z1 + r_q4_z2, 32'd0};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q5_side <= r_q4_side;
            r_q5_p    <= r_q4_p;
            r_q5_d    <= r_q4_d;
            r_q5_c    <= {{25{w_z[63]}}, w_z[63:25]};
        end
    end

    // post 6
    t_side       r_q6_side;
    logic [63:0] r_q6_s;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q6_side <= r_q5_side;
            r_q6_s    <= r_q5_p + r_q5_c + r_q5_d;
        end
    end

    // post 7: final pressure, saturation and output register
    logic [63:0] w_ps;
    logic [31:0] w_psat;

    assign w_ps = {{8{r_q6_s[63]}}, r_q6_s[63:8]} + {{44{w_p7[15]}}, w_p7, 4'd0};

    always_comb begin
        if (w_ps[63]) begin
            w_psat = '0;
        end else if (w_ps[62:32] != '0) begin
            w_psat = '1;
        end else begin
            w_psat = w_ps[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (!r_q6_side.rv) begin
                o_reading_valid         <= 1'b0;
                o_temperature_centi     <= '0;
                o_pressure_q24_8        <= '0;
                o_pressure_divisor_zero <= 1'b0;
                o_humidity_q22_10       <= '0;
            end else begin
                o_reading_valid         <= 1'b1;
                o_temperature_centi     <= r_q6_side.tc;
                o_pressure_q24_8        <= r_q6_side.dz ? 32'd0 : w_psat;
                o_pressure_divisor_zero <= r_q6_side.dz;
                o_humidity_q22_10       <= r_q6_side.hum;
            end
        end
    end

endmodule

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pthc_pkg::*;

    typedef struct packed {
        logic               rv;
        logic signed [15:0] tc;
        logic [31:0]        press;
        logic               dz;
        logic [16:0]        hum;
    } t_reading;

    typedef struct {
        logic [19:0] raw_p;
        logic [19:0] raw_t;
        logic [15:0] raw_h;
        t_reading    typed;
    } t_row;

    localparam longint PRESS_MAX = 64'sh0000_0000_FFFF_FFFF;
    localparam int     HUM_MAX   = 419430400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [19:0] i_raw_pressure = '0;
    logic [19:0] i_raw_temperature = '0;
    logic [15:0] i_raw_humidity = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_reading_valid;
    logic signed [15:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic        o_pressure_divisor_zero;
    logic [16:0] o_humidity_q22_10;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // calibration shadow
    logic [47:0] temp_cal;
    logic [63:0] press_cal_lo;
    logic [63:0] press_cal_hi;
    logic [47:0] press_hum_cal;
    logic [31:0] hum_cal;

    t_reading pending_readings[$];
    int       mismatches = 0;
    int       readings_sent = 0;
    int       readings_checked = 0;
    int       cal_writes = 0;
    int       send_gap_pct = 0;
    int       stall_pct = 0;
    int       hold_off_cycles = 0;

    always #4 i_clk = ~i_clk;

    pth_sensor_compensation u_top (.*);

    function automatic t_reading compensate(input logic [19:0] ap, input logic [19:0] at,
                                            input logic [15:0] ah);
        longint   t1, t2, t3, v1, v2, dt, tf, tc, a, b, p, c, d, num;
        int       hv, hx, hy, hh;
        t_reading r;
        r = '0;
        if (at == 20'd0 || at == 20'hFFFFF) return r;
        r.rv = 1'b1;

        t1 = longint'(temp_cal[15:0]);
        t2 = longint'($signed(temp_cal[31:16]));
        t3 = longint'($signed(temp_cal[47:32]));
        v1 = ((longint'(at >> 3) - (t1 <<< 1)) * t2) >>> 11;
        dt = longint'(at >> 4) - t1;
        v2 = (((dt * dt) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        tc = (tf * 5 + 128) >>> 8;
        if (tc > 32767) tc = 32767;
        if (tc < -32768) tc = -32768;
        r.tc = tc[15:0];

        a = tf - 128000;
        b = a * a * longint'($signed(press_cal_hi[31:16]));
        b = b + ((a * longint'($signed(press_cal_hi[15:0]))) <<< 17);
        b = b + (longint'($signed(press_cal_lo[63:48])) <<< 35);
        a = ((a * a * longint'($signed(press_cal_lo[47:32]))) >>> 8)
            + ((a * longint'($signed(press_cal_lo[31:16]))) <<< 12);
        a = (((longint'(1) <<< 47) + a) * longint'(press_cal_lo[15:0])) >>> 33;
        if (a == 0) begin
            r.dz = 1'b1;
        end else begin
            p   = 1048576 - longint'(ap);
            num = ((p <<< 31) - b) * 3125;
            // most negative / -1 wraps back onto itself
            if (a == -1) p = -num;
            else p = num / a;
            c = (longint'($signed(press_hum_cal[15:0])) * (p >>> 13) * (p >>> 13)) >>> 25;
            d = (longint'($signed(press_cal_hi[63:48])) * p) >>> 19;
            p = ((p + c + d) >>> 8) + (longint'($signed(press_cal_hi[47:32])) <<< 4);
            if (p < 0) p = 0;
            if (p > PRESS_MAX) p = PRESS_MAX;
            r.press = p[31:0];
        end

        hv = int'(tf[31:0]) - 76800;
        hx = (int'(ah) <<< 14) - (int'($signed(hum_cal[11:0])) <<< 20)
             - (int'($signed(hum_cal[23:12])) * hv) + 16384;
        hx = hx >>> 15;
        hy = ((hv * int'($signed(hum_cal[31:24]))) >>> 10)
             * (((hv * int'(press_hum_cal[47:40])) >>> 11) + 32768);
        hy = (hy >>> 10) + 2097152;
        hy = hy * int'($signed(press_hum_cal[39:24])) + 8192;
        hy = hy >>> 14;
        hh = hx * hy;
        hh = hh - (((((hh >>> 15) * (hh >>> 15)) >>> 7) * int'(press_hum_cal[23:16])) >>> 4);
        if (hh < 0) hh = 0;
        if (hh > HUM_MAX) hh = HUM_MAX;
        r.hum = hh[28:12];
        return r;
    endfunction

    // receiver side: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready     <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_reading got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_reading_valid, o_temperature_centi, o_pressure_q24_8,
                    o_pressure_divisor_zero, o_humidity_q22_10};
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading %p", $time, got);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (got.rv !== want.rv) begin
                    $display("%0t: reading_valid exp %0d got %0d", $time, want.rv, got.rv);
                    mismatches++;
                end
                if (got.tc !== want.tc) begin
                    $display("%0t: temperature_centi exp %0d got %0d", $time, want.tc, got.tc);
                    mismatches++;
                end
                if (got.press !== want.press) begin
                    $display("%0t: pressure_q24_8 exp %0h got %0h", $time,
                             want.press, got.press);
                    mismatches++;
                end
                if (got.dz !== want.dz) begin
                    $display("%0t: pressure_divisor_zero exp %0d got %0d", $time,
                             want.dz, got.dz);
                    mismatches++;
                end
                if (got.hum !== want.hum) begin
                    $display("%0t: humidity_q22_10 exp %0d got %0d", $time, want.hum, got.hum);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_reading(input logic [19:0] ap, input logic [19:0] at,
                                input logic [15:0] ah, input bit use_typed,
                                input t_reading typed);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= ap;
        i_raw_temperature <= at;
        i_raw_humidity    <= ah;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_readings.push_back(use_typed ? typed : compensate(ap, at, ah));
        readings_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        release_input();
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (90) @(posedge i_clk);
    endtask

    task automatic write_cal(input t_cfg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TEMP_CAL:      temp_cal      = value[47:0];
            CFG_PRESS_CAL_LO:  press_cal_lo  = value;
            CFG_PRESS_CAL_HI:  press_cal_hi  = value;
            CFG_PRESS_HUM_CAL: press_hum_cal = value[47:0];
            CFG_HUM_CAL:       hum_cal       = value[31:0];
            default: ;
        endcase
        cal_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] tc, input logic [63:0] plo,
                            input logic [63:0] phi, input logic [47:0] phc,
                            input logic [31:0] hc);
        write_cal(CFG_TEMP_CAL, {16'd0, tc});
        write_cal(CFG_PRESS_CAL_LO, plo);
        write_cal(CFG_PRESS_CAL_HI, phi);
        write_cal(CFG_PRESS_HUM_CAL, {16'd0, phc});
        write_cal(CFG_HUM_CAL, {32'd0, hc});
    endtask

    // typical part: T1 27504 T2 26435 T3 -1000, P1..P9, H1..H6
    task automatic load_typical_cal();
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 {8'd0, 16'd362, 8'd75, 16'd6000},
                 {8'd30, 12'd50, 12'd313});
    endtask

    localparam t_reading AT_RESET = '{1'b1, 16'sd0, 32'd0, 1'b1, 17'd0};
    localparam t_reading REJECTED = '0;

    t_row directed_rows[$] = '{
        '{20'h00000, 20'h00000, 16'h0000, REJECTED},
        '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, REJECTED},
        '{20'h5A5A5, 20'h00000, 16'h1234, REJECTED},
        '{20'h12345, 20'hFFFFF, 16'hABCD, REJECTED},
        '{20'h00000, 20'h00001, 16'h0000, AT_RESET},
        '{20'hFFFFF, 20'hFFFFE, 16'hFFFF, AT_RESET},
        '{20'h00000, 20'h80000, 16'h8000, AT_RESET},
        '{20'hFFFFF, 20'h7FFFF, 16'h7FFF, AT_RESET},
        '{20'h65A00, 20'h7E9C0, 16'h6A20, AT_RESET},
        '{20'hAAAAA, 20'h55555, 16'hAAAA, AT_RESET},
        '{20'h55555, 20'hAAAAA, 16'h5555, AT_RESET},
        '{20'h80000, 20'h00010, 16'h0001, AT_RESET},
        '{20'h00001, 20'hFFFF0, 16'hFFFE, AT_RESET},
        '{20'h7FFFF, 20'h6B000, 16'h0000, AT_RESET}
    };

    task automatic walk_directed(input bit cal_at_reset);
        t_row row;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_reading(row.raw_p, row.raw_t, row.raw_h,
                         cal_at_reset || row.raw_t == 20'd0 || row.raw_t == 20'hFFFFF,
                         row.typed);
        end
        drain();
    endtask

    task automatic random_burst(input int count);
        logic [19:0] at, ap;
        for (int n = 0; n < count; n++) begin
            ap = 20'($urandom_range(20'hFFFFF));
            case ($urandom_range(19))
                0:       at = 20'd0;
                1:       at = 20'hFFFFF;
                2, 3, 4: at = 20'($urandom_range(20'hFFFFF));
                default: at = 20'($urandom_range(20'h8FFFF, 20'h6A000));
            endcase
            if ($urandom_range(3) != 0) ap = 20'($urandom_range(20'h70000, 20'h40000));
            send_reading(ap, at, 16'($urandom_range(16'hFFFF)), 1'b0, REJECTED);
        end
    endtask

    initial begin
        temp_cal      = '0;
        press_cal_lo  = '0;
        press_cal_hi  = '0;
        press_hum_cal = '0;
        hum_cal       = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        walk_directed(1'b1);
        load_typical_cal();
        walk_directed(1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0, 4: load_typical_cal();
                2:    load_cal('1, '1, '1, '1, '1);
                5:    load_cal({16'hFC18, 16'd26435, 16'd27504}, 64'd0,
                               {$urandom, $urandom}, 48'd0, 32'd0);
                6:    load_cal('0, '0, '0, '0, '0);
                default:
                      load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                               {$urandom, $urandom}, 48'({$urandom, $urandom}), $urandom);
            endcase
            case (phase % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 78; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 78; end
                default: begin send_gap_pct = 19; stall_pct = 19; end
            endcase
            // long receiver hold-off so the pipeline fills and backs up the input
            if (phase == 0) hold_off_cycles = 300;
            random_burst(190);
            drain();
        end

        $display("covered %0d readings over %0d calibration writes, %0d checked",
                 readings_sent, cal_writes, readings_checked);
        $display("idle patterns: none, sender gaps, receiver stalls, both, plus hold-off");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
